FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator top level.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/wca_pkg.sv
// Package for the weighted charge allocator: field widths, mode codes.
// Depends on nothing.
`default_nettype none
package wca_pkg;
    localparam int MAX_JOBS_DEF = 16;
    localparam int SLOTS_DEF    = 32;
    localparam int CAP_W  = 20;
    localparam int CNT_W  = 5;
    localparam int SLOT_W = 5;
    localparam int DEM_W  = 24;
    localparam int RATE_W = 16;
    localparam int WGT_W  = 16;
    localparam int JOB_W  = 4;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_FAIR   = 2'd1,
        MODE_GREEDY = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [0:0] REG_CAP = 1'b0;
    localparam logic [0:0] REG_CNT = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/wca_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module wca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/weighted_charge_allocator_top.sv
// Weighted charge allocator top level: job table, sequencer, shared divider.
// Depends on wca_pkg, wca_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// A load item is followed by a sweep through S_LDCLR that clears the job's
// usage column. A run item walks the jobs one per step through a single
// shared datapath: one usage RAM port, one adder/compare and one 48-bit by
// 22-bit restoring divider for weight*free/weight_sum. A run on an in-range
// slot first sums the slot's usage over the jobs. A fair round scans
// eligibility and the weight sum, then gives, dividing for each eligible job;
// rounds repeat until the capacity is used, nothing is eligible or a round
// delivers nothing. A greedy run makes one selection pass over the jobs for
// each served job plus a closing pass, and each give goes through S_GRD and
// S_GGIVE. Each result goes through S_OUT and S_OUTW, then waits in S_OUTH for
// m_axis_tready. After reset a clearing pass over all MAX_JOBS*SLOTS words
// zeroes the usage memory; no input item is taken during it. Configuration
// writes belong between items while the block is idle, since a run reads
// power_capacity throughout. s_axis_tready is high only while idle.
module weighted_charge_allocator_top #(
    parameter int MAX_JOBS = wca_pkg::MAX_JOBS_DEF,
    parameter int SLOTS    = wca_pkg::SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: job_index[3:0] arrival[8:4] departure[13:9] demand[37:14]
    //        rate_cap[53:38] weight[69:54] slot[74:70], zero to 80 bits
    input  wire logic [79:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_job[3:0] out_slot[8:4] delivered[24:9] remaining[48:25], zero to 56
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEP = MAX_JOBS * SLOTS;
    localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int NW  = $clog2(MAX_JOBS + 1);
    localparam int LIM = (MAX_JOBS < 16) ? MAX_JOBS : 16;
    localparam int UW  = 16;
    localparam int DVW = 48;
    localparam int DCW = $clog2(DVW + 1);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001, S_IDLE  = 17'h00002, S_LDCLR = 17'h00004,
        S_USUM   = 17'h00008, S_USUMW = 17'h00010, S_FSCAN = 17'h00020,
        S_FSCANW = 17'h00040, S_FDIV  = 17'h00080, S_FGIVE = 17'h00100,
        S_FGIVEW = 17'h00200, S_GSEL  = 17'h00400, S_GSELW = 17'h00800,
        S_GGIVE  = 17'h01000, S_OUT   = 17'h02000, S_OUTW  = 17'h04000,
        S_OUTH   = 17'h08000, S_GRD   = 17'h10000
    } state_t;

    state_t state_reg;
    logic [wca_pkg::CAP_W-1:0] cap_reg;
    logic [wca_pkg::CNT_W-1:0] cnt_reg;

    logic [wca_pkg::SLOT_W-1:0] arr_reg [MAX_JOBS];
    logic [wca_pkg::SLOT_W-1:0] dep_reg [MAX_JOBS];
    logic [wca_pkg::DEM_W-1:0]  rem_reg [MAX_JOBS];
    logic [wca_pkg::RATE_W-1:0] rate_reg [MAX_JOBS];
    logic [wca_pkg::WGT_W-1:0]  wgt_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0]        full_reg, el_reg, done_reg;

    logic [AW-1:0] clr_reg;
    logic [JW-1:0] ldjob_reg, j_reg, best_reg;
    logic [NW-1:0] n_reg;
    logic [SW-1:0] t_reg;
    logic [wca_pkg::SLOT_W-1:0] tslot_reg;
    logic          inrange_reg, fair_reg, any_reg, found_reg;
    logic [24:0]   used_reg;
    logic [21:0]   wsum_reg;
    logic [25:0]   round_reg;
    logic [DVW-1:0] dq_reg;
    logic [32:0]   drem_reg;
    logic [DCW-1:0] dcnt_reg;

    // usage RAM
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [UW-1:0] ram_wdata, ram_rdata;
    wca_ram #(.WIDTH(UW), .DEPTH(DEP)) u_usage (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));

    function automatic logic [AW-1:0] adr(input logic [JW-1:0] j, input logic [SW-1:0] t);
        logic [31:0] a;
        a = 32'(j) * 32'(SLOTS) + 32'(t);
        return a[AW-1:0];
    endfunction

    // config
    logic wr_fire;
    assign pready = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
            cnt_reg <= '0;
        end else if (wr_fire && paddr[2+:1] == 1'b0 && paddr[1:0] == 2'b00) begin
            cap_reg <= pwdata[wca_pkg::CAP_W-1:0];
        end else if (wr_fire && paddr == 3'd4) begin
            cnt_reg <= pwdata[wca_pkg::CNT_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == 3'd0) prdata = {12'd0, cap_reg};
        else if (paddr == 3'd4) prdata = {27'd0, cnt_reg};
    end

    // input fields
    logic [wca_pkg::JOB_W-1:0]  in_job;
    logic [wca_pkg::SLOT_W-1:0] in_slot;
    wca_pkg::mode_t in_mode;
    assign in_mode = wca_pkg::mode_t'(s_axis_tuser);
    assign in_job  = s_axis_tdata[3:0];
    assign in_slot = s_axis_tdata[74:70];
    assign s_axis_tready = (state_reg == S_IDLE);
    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // shared per-job view
    logic [UW-1:0] head;
    logic [UW-1:0] usage_cur;
    logic          elig_cur;
    assign usage_cur = ram_rdata;
    always_comb begin
        head = rate_reg[j_reg] - usage_cur;
        elig_cur = inrange_reg && (arr_reg[j_reg] <= tslot_reg) && (tslot_reg <= dep_reg[j_reg])
                   && (usage_cur < rate_reg[j_reg]) && !full_reg[j_reg];
    end

    // one give: min(limit, rem, head), limit from divider or free capacity
    logic [DVW-1:0] give_lim;
    logic [23:0]    give_amt;
    logic [24:0]    free_cap;
    assign free_cap = 25'(cap_reg) - used_reg;
    always_comb begin
        logic [DVW-1:0] m;
        give_lim = fair_reg ? dq_reg : DVW'(free_cap);
        m = give_lim;
        if (DVW'(rem_reg[j_reg]) < m) m = DVW'(rem_reg[j_reg]);
        if (DVW'(head) < m) m = DVW'(head);
        give_amt = m[23:0];
    end

    logic last_job;
    assign last_job = (NW'(j_reg) + NW'(1) == n_reg);

    always_comb begin
        ram_we = 1'b0;
        ram_wdata = '0;
        ram_addr = adr(j_reg, t_reg);
        unique case (state_reg)
            S_CLEAR: begin ram_we = 1'b1; ram_addr = clr_reg; end
            S_LDCLR: begin ram_we = 1'b1; ram_addr = adr(ldjob_reg, SW'(clr_reg)); end
            S_FGIVEW, S_GGIVE: begin
                ram_we = elig_cur;
                ram_wdata = usage_cur + give_amt[UW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            full_reg  <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEP - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (in_fire) begin
                    t_reg <= SW'(in_slot);
                    tslot_reg <= in_slot;
                    inrange_reg <= (32'(in_slot) < 32'(SLOTS));
                    fair_reg <= (in_mode == wca_pkg::MODE_FAIR);
                    n_reg <= (32'(cnt_reg) > LIM) ? NW'(LIM) : NW'(cnt_reg);
                    j_reg <= '0;
                    used_reg <= '0;
                    clr_reg <= '0;
                    if (in_mode == wca_pkg::MODE_LOAD) begin
                        if (32'(in_job) < 32'(MAX_JOBS)) begin
                            ldjob_reg <= JW'(in_job);
                            arr_reg[JW'(in_job)]  <= s_axis_tdata[8:4];
                            dep_reg[JW'(in_job)]  <= s_axis_tdata[13:9];
                            rem_reg[JW'(in_job)]  <= s_axis_tdata[37:14];
                            rate_reg[JW'(in_job)] <= s_axis_tdata[53:38];
                            wgt_reg[JW'(in_job)]  <= s_axis_tdata[69:54];
                            full_reg[JW'(in_job)] <= (s_axis_tdata[37:14] == '0);
                            state_reg <= S_LDCLR;
                        end
                    end else if (in_mode != wca_pkg::MODE_NONE && cnt_reg != '0) begin
                        state_reg <= (32'(in_slot) < 32'(SLOTS)) ? S_USUM : S_OUT;
                    end
                end
                S_LDCLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS - 1)) state_reg <= S_IDLE;
                end
                S_USUM: state_reg <= S_USUMW;
                S_USUMW: begin
                    used_reg <= used_reg + 25'(usage_cur);
                    if (last_job) begin
                        j_reg <= '0;
                        if (fair_reg) begin
                            state_reg <= S_FSCAN;
                            any_reg <= 1'b0; wsum_reg <= '0;
                        end else begin
                            state_reg <= S_GSEL;
                            done_reg <= '0; found_reg <= 1'b0;
                        end
                    end else begin
                        j_reg <= j_reg + JW'(1);
                        state_reg <= S_USUM;
                    end
                end
                // fair: eligibility and weight sum over the jobs
                S_FSCAN: begin
                    if (used_reg >= 25'(cap_reg)) begin
                        j_reg <= '0; state_reg <= S_OUT;
                    end else state_reg <= S_FSCANW;
                end
                S_FSCANW: begin
                    el_reg[j_reg] <= elig_cur;
                    if (elig_cur) begin
                        any_reg <= 1'b1;
                        wsum_reg <= wsum_reg + 22'(wgt_reg[j_reg]);
                    end
                    if (last_job) begin
                        j_reg <= '0;
                        round_reg <= '0;
                        if (!(any_reg || elig_cur) ||
                            (wsum_reg + 22'(elig_cur ? wgt_reg[j_reg] : '0)) == '0)
                            state_reg <= S_OUT;
                        else state_reg <= S_FGIVE;
                        dcnt_reg <= '0;
                    end else begin
                        j_reg <= j_reg + JW'(1);
                        state_reg <= S_FSCAN;
                    end
                end
                S_FGIVE: begin
                    // usage read of this job starts; divide weight*free/wsum if eligible
                    if (el_reg[j_reg]) begin
                        dq_reg <= DVW'(wgt_reg[j_reg]) * DVW'(free_cap);
                        drem_reg <= '0;
                        dcnt_reg <= DCW'(DVW);
                        state_reg <= S_FDIV;
                    end else state_reg <= S_FGIVEW;
                end
                S_FDIV: begin
                    logic [32:0] tr;
                    tr = {drem_reg[31:0], dq_reg[DVW-1]};
                    if (tr >= 33'(wsum_reg)) begin
                        drem_reg <= tr - 33'(wsum_reg);
                        dq_reg <= {dq_reg[DVW-2:0], 1'b1};
                    end else begin
                        drem_reg <= tr;
                        dq_reg <= {dq_reg[DVW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - DCW'(1);
                    if (dcnt_reg == DCW'(1)) state_reg <= S_FGIVEW;
                end
                S_FGIVEW: begin
                    if (el_reg[j_reg]) begin
                        rem_reg[j_reg] <= rem_reg[j_reg] - give_amt;
                        if (rem_reg[j_reg] == give_amt) full_reg[j_reg] <= 1'b1;
                        round_reg <= round_reg + 26'(give_amt);
                    end
                    if (last_job) begin
                        j_reg <= '0;
                        used_reg <= used_reg + round_reg[24:0]
                                    + 25'(el_reg[j_reg] ? give_amt : '0);
                        any_reg <= 1'b0; wsum_reg <= '0;
                        if (round_reg == '0 && !(el_reg[j_reg] && give_amt != '0))
                            state_reg <= S_OUT;
                        else state_reg <= S_FSCAN;
                    end else begin
                        j_reg <= j_reg + JW'(1);
                        state_reg <= S_FGIVE;
                    end
                end
                // greedy: pick heaviest not-yet-served eligible job, lowest index on ties
                S_GSEL: state_reg <= S_GSELW;
                S_GSELW: begin
                    if (elig_cur && !done_reg[j_reg] &&
                        (!found_reg || wgt_reg[j_reg] > wgt_reg[best_reg])) begin
                        found_reg <= 1'b1;
                        best_reg <= j_reg;
                    end
                    if (last_job) begin
                        logic take;
                        take = elig_cur && !done_reg[j_reg] &&
                               (!found_reg || wgt_reg[j_reg] > wgt_reg[best_reg]);
                        if (!(found_reg || take) || used_reg >= 25'(cap_reg)) begin
                            j_reg <= '0; state_reg <= S_OUT;
                        end else begin
                            j_reg <= take ? j_reg : best_reg;
                            state_reg <= S_GRD;
                        end
                    end else begin
                        j_reg <= j_reg + JW'(1);
                        state_reg <= S_GSEL;
                    end
                end
                // address the chosen job's usage; data is there in GGIVE
                S_GRD: state_reg <= S_GGIVE;
                S_GGIVE: begin
                    done_reg[j_reg] <= 1'b1;
                    rem_reg[j_reg] <= rem_reg[j_reg] - give_amt;
                    if (rem_reg[j_reg] == give_amt) full_reg[j_reg] <= 1'b1;
                    used_reg <= used_reg + 25'(give_amt);
                    j_reg <= '0; found_reg <= 1'b0;
                    state_reg <= S_GSEL;
                end
                S_OUT: state_reg <= S_OUTW;
                S_OUTW: begin
                    m_axis_tdata <= {7'd0, rem_reg[j_reg],
                                     inrange_reg ? usage_cur : 16'd0,
                                     tslot_reg, 4'(j_reg)};
                    m_axis_tlast <= last_job;
                    m_axis_tvalid <= 1'b1;
                    state_reg <= S_OUTH;
                end
                S_OUTH: if (m_axis_tready) begin
                    m_axis_tvalid <= 1'b0;
                    if (m_axis_tlast) state_reg <= S_IDLE;
                    else begin
                        j_reg <= j_reg + JW'(1);
                        state_reg <= S_OUT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_idle_only, aclk, aresetn, s_axis_tready, !m_axis_tvalid,
        "input ready while a result is pending")
    `ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `ASSERT_IMP(a_job_range, aclk, aresetn, m_axis_tvalid,
        32'(m_axis_tdata[3:0]) < 32'(MAX_JOBS), "result job index out of range")
endmodule
`default_nettype wire
